[rtl/min_heap_extract_sift_down_unit_macros.svh]
// Assertion shorthands for the heap unit checker.
// All properties sample on i_clk.
`ifndef MIN_HEAP_EXTRACT_SIFT_DOWN_UNIT_MACROS_SVH
`define MIN_HEAP_EXTRACT_SIFT_DOWN_UNIT_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define MHE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while in reset.
`define MHE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked across reset.
`define MHE_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mhe_pkg.sv]
// ----------------------------------------------------------------------------
// mhe_pkg
// Shared types, constants and the record ordering function for the heap unit.
// ----------------------------------------------------------------------------
package mhe_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W      = CNT_W + 1;
    localparam int OCC_W      = 7;

    // command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_CHECK   = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic signed [31:0] id;
        logic [31:0]        pri;
        logic [31:0]        arr;
    } t_rec;

    typedef struct packed {
        logic [1:0]       status;
        t_rec             rec;
        logic             ordered;
        logic [OCC_W-1:0] occupancy;
    } t_result;

    typedef struct packed {
        logic        valid;
        t_result     res;
    } t_fin;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_rec              wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_ram_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XROOT,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_CHECK,
        ST_DONE
    } t_state;

    // a comes before b: lower priority, then earlier arrival
    function automatic logic rec_precedes(input t_rec a, input t_rec b);
        logic r;
        if (a.pri != b.pri) begin
            r = (a.pri < b.pri);
        end else begin
            r = (a.arr < b.arr);
        end
        return r;
    endfunction

endpackage

[rtl/mhe_if.sv]
// ----------------------------------------------------------------------------
// mhe_cmd_if / mhe_rsp_if
// Valid/ready channels for heap commands and their results.
// ----------------------------------------------------------------------------
interface mhe_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] in_alert_id;
    logic [31:0]        in_priority;
    logic [31:0]        in_arrival;

    modport source (output valid, command, in_alert_id, in_priority, in_arrival,
                    input ready);
    modport sink   (input valid, command, in_alert_id, in_priority, in_arrival,
                    output ready);
endinterface

interface mhe_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_alert_id;
    logic [31:0]        out_priority;
    logic [31:0]        out_arrival;
    logic               heap_ordered;
    logic [6:0]         occupancy;

    modport source (output valid, status, out_alert_id, out_priority, out_arrival,
                    heap_ordered, occupancy, input ready);
    modport sink   (input valid, status, out_alert_id, out_priority, out_arrival,
                    heap_ordered, occupancy, output ready);
endinterface

[rtl/min_heap_extract_sift_down_unit.sv]
// One item in flight; the next is taken in the cycle after its result moves to the
// output register. A load, or an extract on an empty heap, goes straight to the done
// state; any other extract reads the root and the last entry and then, unless that
// was the last record, sifts down a level per read and compare step until the item
// settles; a check reads each child/parent pair in turn.
// Reset (synchronous, active low) empties the heap; record memory is not cleared.
// ----------------------------------------------------------------------------
// min_heap_extract_sift_down_unit
// Binary min-heap of records with load, extract-min and order check commands.
// ----------------------------------------------------------------------------
module min_heap_extract_sift_down_unit
    import mhe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mhe_cmd_if.sink   i_cmd,
    mhe_rsp_if.source o_rsp
);

    t_fin     fin;
    logic     fin_ready;
    t_ram_req ram_req;
    t_rec     rd_a;
    t_rec     rd_b;

    // output register: holds one finished item for the response side
    logic     r_out_valid;
    t_result  r_out;

    // Memory of records; root at address 0, children of n at 2n+1 and 2n+2.
    mhe_store u_store (
        .i_clk  (i_clk),
        .i_req  (ram_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    // Sequencer owns the fill count and all memory traffic.
    mhe_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_fin       (fin),
        .i_fin_ready (fin_ready),
        .o_ram_req   (ram_req),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b)
    );

    // Room in the output register when empty or being drained this cycle.
    assign fin_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_ready) begin
            r_out_valid <= fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_ready && fin.valid) begin
            r_out <= fin.res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.out_alert_id = r_out.rec.id;
    assign o_rsp.out_priority = r_out.rec.pri;
    assign o_rsp.out_arrival  = r_out.rec.arr;
    assign o_rsp.heap_ordered = r_out.ordered;
    assign o_rsp.occupancy    = r_out.occupancy;

endmodule

[rtl/mhe_store.sv]
// ----------------------------------------------------------------------------
// mhe_store
// Record memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhe_store
    import mhe_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_rec     o_rd_a,
    output t_rec     o_rd_b
);

    t_rec r_mem [HEAP_DEPTH];
    t_rec r_rd_a;
    t_rec r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_req.raddr_a];
        r_rd_b <= r_mem[i_req.raddr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

[rtl/mhe_seq.sv]
// ----------------------------------------------------------------------------
// mhe_seq
// Command sequencer: load, extract with sift-down, and order check over the
// record memory.
// ----------------------------------------------------------------------------
module mhe_seq
    import mhe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    mhe_cmd_if.sink  i_cmd,
    output t_fin     o_fin,
    input  logic     i_fin_ready,
    output t_ram_req o_ram_req,
    input  t_rec     i_rd_a,
    input  t_rec     i_rd_b
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_hole, n_hole;
    t_rec              r_item, n_item;
    t_result           r_res, n_res;
    logic [CNT_W-1:0]  r_c, n_c;
    logic              r_pend, n_pend;
    logic              r_bad, n_bad;

    logic              accept;
    t_rec              in_rec;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  c_par;
    logic [IDX_W-1:0]  pick_l;
    logic [IDX_W-1:0]  pick_r;
    logic              take_r;
    t_rec              child;
    logic [IDX_W-1:0]  child_idx;

    assign accept = i_cmd.valid && i_cmd.ready;
    assign in_rec = '{id: i_cmd.in_alert_id, pri: i_cmd.in_priority,
                      arr: i_cmd.in_arrival};
    assign cnt_m1 = r_count - CNT_W'(1);
    assign c_par  = (r_c - CNT_W'(1)) >> 1;
    assign pick_l = IDX_W'({r_hole, 1'b1});
    assign pick_r = pick_l + IDX_W'(1);
    // right child only counts while it is inside the heap
    assign take_r = (pick_r < IDX_W'(r_count)) && rec_precedes(i_rd_b, i_rd_a);
    assign child     = take_r ? i_rd_b : i_rd_a;
    assign child_idx = take_r ? pick_r : pick_l;

    assign i_cmd.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole <= n_hole;
        r_item <= n_item;
        r_res  <= n_res;
        r_c    <= n_c;
        r_bad  <= n_bad;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_hole  = r_hole;
        n_item  = r_item;
        n_res   = r_res;
        n_c     = r_c;
        n_pend  = r_pend;
        n_bad   = r_bad;

        o_ram_req         = '0;
        o_ram_req.waddr   = r_hole;
        o_ram_req.wdata   = r_item;

        o_fin.valid         = (r_state == ST_DONE);
        o_fin.res           = r_res;
        o_fin.res.occupancy = OCC_W'(r_count);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    unique case (i_cmd.command)
                        CMD_LOAD: begin
                            if (r_count >= CNT_W'(HEAP_DEPTH)) begin
                                n_res.status = STS_FULL;
                            end else begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = r_count[ADDR_W-1:0];
                                o_ram_req.wdata = in_rec;
                                n_count         = r_count + CNT_W'(1);
                            end
                            n_state = ST_DONE;
                        end
                        CMD_EXTRACT: begin
                            if (r_count == '0) begin
                                n_res.status = STS_EMPTY;
                                n_state      = ST_DONE;
                            end else begin
                                o_ram_req.raddr_a = '0;
                                o_ram_req.raddr_b = cnt_m1[ADDR_W-1:0];
                                n_state           = ST_XROOT;
                            end
                        end
                        CMD_CHECK: begin
                            n_c     = CNT_W'(1);
                            n_pend  = 1'b0;
                            n_bad   = 1'b0;
                            n_state = ST_CHECK;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_XROOT: begin
                // root leaves, last entry becomes the item to sift
                n_res.rec = i_rd_a;
                n_item    = i_rd_b;
                n_count   = cnt_m1;
                n_hole    = '0;
                n_state   = (cnt_m1 == '0) ? ST_DONE : ST_SIFT_RD;
            end
            ST_SIFT_RD: begin
                if (pick_l >= IDX_W'(r_count)) begin
                    o_ram_req.we = 1'b1;
                    n_state      = ST_DONE;
                end else begin
                    o_ram_req.raddr_a = pick_l[ADDR_W-1:0];
                    o_ram_req.raddr_b = pick_r[ADDR_W-1:0];
                    n_state           = ST_SIFT_CMP;
                end
            end
            ST_SIFT_CMP: begin
                o_ram_req.we = 1'b1;
                if (rec_precedes(child, r_item)) begin
                    o_ram_req.wdata = child;
                    n_hole          = child_idx[ADDR_W-1:0];
                    n_state         = ST_SIFT_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CHECK: begin
                // one child/parent pair read per cycle, compared in the cycle after its read
                if (r_pend && rec_precedes(i_rd_a, i_rd_b)) begin
                    n_bad = 1'b1;
                end
                if (r_c < r_count) begin
                    o_ram_req.raddr_a = r_c[ADDR_W-1:0];
                    o_ram_req.raddr_b = c_par[ADDR_W-1:0];
                    n_c               = r_c + CNT_W'(1);
                    n_pend            = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_res.ordered = !r_bad;
                        n_state       = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_fin_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/mhe_chk.sv]
// ----------------------------------------------------------------------------
// mhe_chk
// Port-level checks on the heap unit's response channel.
// ----------------------------------------------------------------------------
`include "min_heap_extract_sift_down_unit_macros.svh"

module mhe_chk
    import mhe_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic [1:0]         i_status,
    input logic signed [31:0] i_id,
    input logic [31:0]        i_pri,
    input logic [31:0]        i_arr,
    input logic [6:0]         i_occ
);

    `MHE_ASSERT_RST(a_rst_quiet, !i_rst_n, !i_rsp_valid, "response valid right after reset")
    `MHE_ASSERT_NEXT(a_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_occ), "stalled response changed")
    `MHE_ASSERT_NOW(a_err_zero, i_rsp_valid && (i_status != STS_OK), (i_id == 0) && (i_pri == 0) && (i_arr == 0), "error response carries a record")
    `MHE_ASSERT_NOW(a_empty_occ, i_rsp_valid && (i_status == STS_EMPTY), i_occ == 7'd0, "empty status with nonzero occupancy")

endmodule

bind min_heap_extract_sift_down_unit mhe_chk u_mhe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_id        (o_rsp.out_alert_id),
    .i_pri       (o_rsp.out_priority),
    .i_arr       (o_rsp.out_arrival),
    .i_occ       (o_rsp.occupancy)
);

[tb/min_heap_extract_sift_down_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_extract_sift_down_unit_checker
// Watches the command and result channels, keeps a shadow heap, predicts
// each result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module min_heap_extract_sift_down_unit_checker
    import mhe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mhe_cmd_if   i_cmd,
    mhe_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int REPORT_MAX = 10;

    t_rec        heap_mem [HEAP_DEPTH];
    int unsigned heap_len;
    t_result     result_q [$];
    int          fails;

    // lower priority first, earlier arrival on a tie
    function automatic logic comes_first(input t_rec a, input t_rec b);
        if (a.pri != b.pri) begin
            return a.pri < b.pri;
        end
        return a.arr < b.arr;
    endfunction

    task automatic predict_result(input logic [1:0] op, input t_rec rec,
                                  output t_result res);
        int unsigned hole;
        int unsigned pick;
        int unsigned c;
        t_rec        moving;
        logic        in_order;
        res = '0;
        case (op)
            CMD_LOAD: begin
                if (heap_len >= HEAP_DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    heap_mem[heap_len] = rec;
                    heap_len++;
                end
            end
            CMD_EXTRACT: begin
                if (heap_len == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    res.rec = heap_mem[0];
                    heap_len--;
                    if (heap_len > 0) begin
                        // last entry drops into the root, then sinks
                        moving = heap_mem[heap_len];
                        hole   = 0;
                        pick   = 1;
                        while (pick < heap_len) begin
                            if (pick + 1 < heap_len &&
                                comes_first(heap_mem[pick + 1], heap_mem[pick])) begin
                                pick++;
                            end
                            if (!comes_first(heap_mem[pick], moving)) begin
                                break;
                            end
                            heap_mem[hole] = heap_mem[pick];
                            hole = pick;
                            pick = 2 * hole + 1;
                        end
                        heap_mem[hole] = moving;
                    end
                end
            end
            CMD_CHECK: begin
                in_order = 1'b1;
                for (c = 1; c < heap_len; c++) begin
                    if (comes_first(heap_mem[c], heap_mem[(c - 1) / 2])) begin
                        in_order = 1'b0;
                    end
                end
                res.ordered = in_order;
            end
            default: begin
                // unused code: no operation
            end
        endcase
        res.occupancy = OCC_W'(heap_len);
    endtask

    always @(posedge i_clk) begin
        t_result exp_res;
        t_result got_res;
        t_rec    in_rec;
        if (!i_rst_n) begin
            heap_len = 0;
            fails    = 0;
            result_q.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got_res.status     = i_rsp.status;
                got_res.rec.id     = i_rsp.out_alert_id;
                got_res.rec.pri    = i_rsp.out_priority;
                got_res.rec.arr    = i_rsp.out_arrival;
                got_res.ordered    = i_rsp.heap_ordered;
                got_res.occupancy  = i_rsp.occupancy;
                if (result_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX) begin
                        $display("%0t: result with nothing pending: sts=%0d id=%0d occ=%0d",
                                 $realtime, got_res.status, got_res.rec.id,
                                 got_res.occupancy);
                    end
                end else begin
                    exp_res = result_q.pop_front();
                    if (got_res.status    !== exp_res.status  ||
                        got_res.rec.id    !== exp_res.rec.id  ||
                        got_res.rec.pri   !== exp_res.rec.pri ||
                        got_res.rec.arr   !== exp_res.rec.arr ||
                        got_res.ordered   !== exp_res.ordered ||
                        got_res.occupancy !== exp_res.occupancy) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display({"%0t: mismatch exp sts=%0d id=%0d pri=%h arr=%h ",
                                      "ord=%b occ=%0d | got sts=%0d id=%0d pri=%h arr=%h ",
                                      "ord=%b occ=%0d"},
                                     $realtime, exp_res.status, exp_res.rec.id,
                                     exp_res.rec.pri, exp_res.rec.arr, exp_res.ordered,
                                     exp_res.occupancy, got_res.status, got_res.rec.id,
                                     got_res.rec.pri, got_res.rec.arr, got_res.ordered,
                                     got_res.occupancy);
                        end
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                in_rec.id  = i_cmd.in_alert_id;
                in_rec.pri = i_cmd.in_priority;
                in_rec.arr = i_cmd.in_arrival;
                predict_result(i_cmd.command, in_rec, exp_res);
                result_q.push_back(exp_res);
            end
            o_pending    <= result_q.size();
            o_fail_count <= fails;
        end
    end

endmodule

[tb/min_heap_extract_sift_down_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_extract_sift_down_unit_test
// Drives load, extract, check and no-op commands into the heap unit with random
// gaps and result back-pressure; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module min_heap_extract_sift_down_unit_test;
    import mhe_pkg::*;

    localparam time         CLK_HALF     = 5ns;
    localparam logic [1:0]  CMD_NOP      = 2'd3;   // unused code, must be a no-op
    localparam int unsigned RANDOM_ITEMS = 500;
    // Slowest item: a check over 64 entries plus the longest sender gap plus the
    // longest result stall; the limit covers that many times over.
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned TAIL_CYCLES  = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mhe_cmd_if cmd_bus ();
    mhe_rsp_if rsp_bus ();

    int fail_count;
    int pending;

    // stimulus bookkeeping
    int unsigned items_sent;
    int unsigned occ_shadow;      // occupancy as the sender sees it
    logic [31:0] key_floor;       // running floor for ascending loads
    logic [31:0] arrival_seq;
    bit          tx_burst;        // sender runs without gaps
    bit          rx_burst;        // receiver starts no new stalls
    int unsigned rx_hold;
    int unsigned idle_cycles;

    min_heap_extract_sift_down_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    min_heap_extract_sift_down_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Narrow records pile up ties on priority and arrival.
    function automatic t_rec random_rec(input bit narrow);
        t_rec r;
        r.id = $urandom;
        if (narrow) begin
            r.pri = $urandom_range(0, 3);
            r.arr = $urandom_range(0, 7);
        end else begin
            r.pri = $urandom;
            r.arr = $urandom;
        end
        return r;
    endfunction

    // Next record above everything loaded in ascending order so far; keeps
    // a heap built this way in order.
    function automatic t_rec ascending_rec();
        t_rec r;
        if (key_floor > 32'hFFFF_0000) begin
            key_floor = $urandom_range(0, 1000);
        end
        key_floor   = key_floor + $urandom_range(0, 2);
        arrival_seq = arrival_seq + $urandom_range(1, 3);
        r.id  = $urandom;
        r.pri = key_floor;
        r.arr = arrival_seq;
        return r;
    endfunction

    // Result side: ready drops for random stretches unless in burst mode.
    initial begin
        rsp_bus.ready = 1'b0;
        rx_hold       = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold != 0) begin
                rsp_bus.ready <= 1'b0;
                rx_hold--;
            end else begin
                rsp_bus.ready <= 1'b1;
                if (!rx_burst) begin
                    rx_hold = pick_idle_len();
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) ||
                (rsp_bus.valid && rsp_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // One command item; valid stays up into the next item when no gap is drawn.
    task automatic send_item(input logic [1:0] op, input t_rec rec);
        int unsigned gap;
        gap = tx_burst ? 0 : pick_idle_len();
        if (gap != 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.command     <= op;
        cmd_bus.in_alert_id <= rec.id;
        cmd_bus.in_priority <= rec.pri;
        cmd_bus.in_arrival  <= rec.arr;
        @(posedge i_clk);
        while (!cmd_bus.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
        if (op == CMD_LOAD && occ_shadow < HEAP_DEPTH) begin
            occ_shadow++;
        end else if (op == CMD_EXTRACT && occ_shadow > 0) begin
            occ_shadow--;
        end
    endtask

    function automatic t_rec make_rec(input logic signed [31:0] id,
                                      input logic [31:0] pri, input logic [31:0] arr);
        t_rec r;
        r.id  = id;
        r.pri = pri;
        r.arr = arr;
        return r;
    endfunction

    // Hold off the sender until every pending result is back. The pending count is
    // read only once it can include an item taken at the last edge.
    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Load up to capacity, push a few loads into the full heap, then check
    // and take a few out.
    task automatic fill_to_full();
        bit          asc;
        int unsigned n;
        asc = $urandom_range(0, 1);
        while (occ_shadow < HEAP_DEPTH) begin
            send_item(CMD_LOAD, asc ? ascending_rec() : random_rec($urandom_range(0, 1)));
        end
        n = $urandom_range(1, 3);
        repeat (n) send_item(CMD_LOAD, random_rec(1'b0));
        send_item(CMD_CHECK, random_rec(1'b0));
        n = $urandom_range(1, 8);
        repeat (n) send_item(CMD_EXTRACT, random_rec(1'b0));
    endtask

    task automatic mixed_run(input int unsigned n);
        int unsigned r;
        bit          narrow;
        narrow = $urandom_range(0, 1);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_item(CMD_LOAD, random_rec(narrow));
            end else if (r < 80) begin
                send_item(CMD_EXTRACT, random_rec(1'b0));
            end else if (r < 95) begin
                send_item(CMD_CHECK, random_rec(1'b0));
            end else begin
                send_item(CMD_NOP, random_rec(1'b0));
            end
        end
    endtask

    initial begin
        int unsigned random_start;
        int unsigned seg;
        int unsigned n;

        i_rst_n             = 1'b0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.command     = CMD_LOAD;
        cmd_bus.in_alert_id = '0;
        cmd_bus.in_priority = '0;
        cmd_bus.in_arrival  = '0;
        items_sent          = 0;
        occ_shadow          = 0;
        key_floor           = $urandom_range(0, 1000);
        arrival_seq         = $urandom_range(0, 1000);
        tx_burst            = 1'b0;
        rx_burst            = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        send_item(CMD_EXTRACT, make_rec(0, 0, 0));          // extract on empty heap
        send_item(CMD_CHECK,   make_rec(0, 0, 0));          // check on empty heap
        send_item(CMD_NOP,     make_rec(-1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(CMD_LOAD,    make_rec(32'sh8000_0000, 32'h0, 32'h0));
        send_item(CMD_CHECK,   make_rec(0, 0, 0));          // single record is ordered
        send_item(CMD_EXTRACT, make_rec(0, 0, 0));          // back to empty
        // root at the top of the key range: heap out of order
        send_item(CMD_LOAD,    make_rec(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(CMD_LOAD,    make_rec(-1, 32'd5, 32'd9));
        send_item(CMD_LOAD,    make_rec(0, 32'd5, 32'd3));   // same priority, earlier
        send_item(CMD_LOAD,    make_rec(1234, 32'd5, 32'd3)); // identical key
        send_item(CMD_LOAD,    make_rec(77, 32'd2, 32'hFFFF_FFFF));
        send_item(CMD_CHECK,   make_rec(0, 0, 0));
        send_item(CMD_NOP,     make_rec(32'sh5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        repeat (6) send_item(CMD_EXTRACT, make_rec(0, 0, 0)); // last one hits empty
        send_item(CMD_LOAD,    make_rec(10, 32'd1, 32'd0));
        send_item(CMD_LOAD,    make_rec(11, 32'd2, 32'd0));
        send_item(CMD_LOAD,    make_rec(12, 32'd2, 32'd1));
        send_item(CMD_CHECK,   make_rec(0, 0, 0));
        send_item(CMD_EXTRACT, make_rec(0, 0, 0));
        send_item(CMD_EXTRACT, make_rec(0, 0, 0));

        // sender waits out every pending result once
        drain_results();

        // ---- random part ----
        random_start = items_sent;
        fill_to_full();
        while (items_sent - random_start < RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            seg = $urandom_range(0, 99);
            if (seg < 30) begin
                // ordered build-up, checks sprinkled in
                if (occ_shadow == 0) begin
                    key_floor = $urandom_range(0, 1000);
                end
                n = $urandom_range(1, 24);
                repeat (n) begin
                    if ($urandom_range(0, 5) == 0) begin
                        send_item(CMD_CHECK, random_rec(1'b0));
                    end
                    send_item(CMD_LOAD, ascending_rec());
                end
                send_item(CMD_CHECK, random_rec(1'b0));
            end else if (seg < 55) begin
                n = $urandom_range(1, 20);
                repeat (n) begin
                    send_item($urandom_range(0, 4) == 0 ? CMD_CHECK : CMD_EXTRACT,
                              random_rec(1'b0));
                end
            end else if (seg < 85) begin
                mixed_run($urandom_range(5, 30));
            end else if (seg < 95) begin
                fill_to_full();
            end else begin
                drain_results();
            end
        end

        // ---- wind down ----
        rx_burst = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[min_heap_extract_sift_down_unit.f]
+incdir+rtl
rtl/mhe_pkg.sv
rtl/mhe_if.sv
rtl/mhe_store.sv
rtl/mhe_seq.sv
rtl/min_heap_extract_sift_down_unit.sv
rtl/mhe_chk.sv
tb/min_heap_extract_sift_down_unit_checker.sv
tb/min_heap_extract_sift_down_unit_test.sv
